[sv/pap_pkg.sv]
// Shared constants, payload types, sequencer states and angle helpers.
`timescale 1ns / 1ps
package pap_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int ADDR_BITS  = $clog2(MAX_POINTS);
    localparam int SUM_BITS   = COORD_BITS + CNT_BITS;
    localparam int D_BITS     = SUM_BITS + 1;
    localparam int PROD_BITS  = 2 * D_BITS;
    localparam int PT_BITS    = 2 * COORD_BITS;
    localparam int TERM_BITS  = 2 * COORD_BITS;
    localparam int ACC_BITS   = 2 * COORD_BITS + CNT_BITS + 1;
    localparam int AREA_BITS  = 38;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_coord;
        logic signed [COORD_BITS-1:0] y_coord;
        logic                         last_vertex;
    } t_vertex;

    typedef struct packed {
        logic [AREA_BITS-1:0] double_area;
        logic                 too_many_points;
    } t_result;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_coord;
        logic signed [COORD_BITS-1:0] y_coord;
    } t_point;

    typedef enum logic [3:0] {
        S_LOAD,
        S_KEY_RD,
        S_KEY_WAIT,
        S_E_RD,
        S_E_WAIT,
        S_MUL,
        S_CMP,
        S_PUT,
        S_A_RD,
        S_A_WAIT,
        S_A_WRAP,
        S_A_MUL,
        S_A_ACC,
        S_DONE
    } t_state;

    // Angle classes in sort order: lower half, zero angle, upper half, pi.
    typedef enum logic [1:0] {
        AC_NEG,
        AC_ZERO,
        AC_POS,
        AC_PI
    } t_aclass;

    function automatic t_aclass angle_class(input logic signed [D_BITS-1:0] dx,
                                            input logic signed [D_BITS-1:0] dy);
        t_aclass c;
        if (dy < 0) begin
            c = AC_NEG;
        end else if (dy > 0) begin
            c = AC_POS;
        end else if (dx >= 0) begin
            c = AC_ZERO;
        end else begin
            c = AC_PI;
        end
        return c;
    endfunction

    // n*p - S : offset from the centroid, scaled by the point count
    function automatic logic signed [D_BITS-1:0] centered(
        input logic signed [COORD_BITS-1:0] p,
        input logic [CNT_BITS-1:0]          n,
        input logic signed [SUM_BITS-1:0]   s);
        logic signed [D_BITS-1:0] m;
        m = $signed(D_BITS'({1'b0, n})) * D_BITS'(p);
        return m - D_BITS'(s);
    endfunction

endpackage

[sv/pap_vtx_if.sv]
// Vertex input channel: valid, ready and one vertex word.
`timescale 1ns / 1ps
interface pap_vtx_if;
    import pap_pkg::*;
    logic    valid;
    logic    ready;
    t_vertex data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/pap_res_if.sv]
// Result output channel: valid, ready and one area word.
`timescale 1ns / 1ps
interface pap_res_if;
    import pap_pkg::*;
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/pap_ram.sv]
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module pap_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[sv/pap_angle.sv]
// Exact angle comparator: registered cross products and angle classes.
`timescale 1ns / 1ps
module pap_angle (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [pap_pkg::D_BITS-1:0]   i_kdx,
    input  logic signed [pap_pkg::D_BITS-1:0]   i_kdy,
    input  logic signed [pap_pkg::D_BITS-1:0]   i_edx,
    input  logic signed [pap_pkg::D_BITS-1:0]   i_edy,
    output logic                                o_less
);
    import pap_pkg::*;

    logic signed [PROD_BITS-1:0] r_p;
    logic signed [PROD_BITS-1:0] r_q;
    t_aclass                     r_ca;
    t_aclass                     r_cb;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p  <= i_kdx * i_edy;
            r_q  <= i_kdy * i_edx;
            r_ca <= angle_class(i_kdx, i_kdy);
            r_cb <= angle_class(i_edx, i_edy);
        end
    end

    // key before element: lower class, or same half-plane and the element lies counterclockwise of the key
    always_comb begin
        if (r_ca != r_cb) begin
            o_less = (r_ca < r_cb);
        end else if (r_ca == AC_ZERO || r_ca == AC_PI) begin
            o_less = 1'b0;
        end else begin
            o_less = (r_p > r_q);
        end
    end
endmodule

[sv/polygon_angular_sort_area.sv]
// Top level: polygon vertex store, angular insertion sort and shoelace area.
`timescale 1ns / 1ps
// Usage:
//   i_vtx carries one vertex word per handshake (x_coord, y_coord, last_vertex).
//   Vertices load at one word per cycle into a point RAM while the running
//   coordinate sums build up. Up to MAX_POINTS vertices are kept; words beyond
//   that are dropped and flag too_many_points. The word with last_vertex set
//   closes the polygon and ready drops while the block works.
//   Closing runs an insertion sort by angle around the centroid out of the
//   point RAM: each compare reads an element, centers it when the read data
//   arrives, forms the cross products, then compares and writes back. Each
//   outer pass first fetches and centers the key; a key that lands in slot
//   zero is written back in a separate step.
//   The shoelace pass then reads each point, multiplies it with the one
//   before and accumulates, then wraps back to the first point to close the
//   polygon; a final step registers the result.
//   o_res delivers one word per polygon (double_area, too_many_points) from an
//   output register. If the receiver stalls, the block loads the next polygon
//   anyway and only waits at its close until the held word is taken.
//   Reset (synchronous, active low) clears the count, sums, overflow flag,
//   sequencer and output valid; the point RAM needs no clearing.
module polygon_angular_sort_area (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pap_vtx_if.sink    i_vtx,
    pap_res_if.source  o_res
);
    import pap_pkg::*;

    t_state                         r_state;
    t_state                         n_state;
    logic [CNT_BITS-1:0]            r_count;
    logic signed [SUM_BITS-1:0]     r_sum_x;
    logic signed [SUM_BITS-1:0]     r_sum_y;
    logic                           r_ovf;
    logic [CNT_BITS-1:0]            r_i;
    logic [CNT_BITS-1:0]            r_j;
    t_point                         r_key;
    t_point                         r_e;
    logic signed [D_BITS-1:0]       r_kdx;
    logic signed [D_BITS-1:0]       r_kdy;
    logic signed [D_BITS-1:0]       r_edx;
    logic signed [D_BITS-1:0]       r_edy;
    t_point                         r_first;
    t_point                         r_prev;
    t_point                         r_cur;
    logic signed [TERM_BITS-1:0]    r_t1;
    logic signed [TERM_BITS-1:0]    r_t2;
    logic signed [ACC_BITS-1:0]     r_acc;
    logic                           r_wrap;
    logic                           r_out_valid;
    t_result                        r_out;

    logic                 w_accept;
    logic                 w_room;
    logic [CNT_BITS-1:0]  w_cnt_next;
    logic                 w_i_last;
    logic                 w_less;
    logic                 w_we;
    logic [ADDR_BITS-1:0] w_waddr;
    t_point               w_wdata;
    logic [ADDR_BITS-1:0] w_raddr;
    logic [PT_BITS-1:0]   w_rdata;
    t_point               w_rpt;
    logic [ACC_BITS-1:0]  w_abs;

    assign w_accept   = i_vtx.valid && i_vtx.ready;
    assign w_room     = (r_count < CNT_BITS'(MAX_POINTS));
    assign w_cnt_next = w_room ? r_count + 1'b1 : r_count;
    assign w_i_last   = ((r_i + 1'b1) == r_count);
    assign w_rpt      = t_point'(w_rdata);
    assign w_abs      = r_acc[ACC_BITS-1] ? ACC_BITS'(-r_acc) : ACC_BITS'(r_acc);

    assign i_vtx.ready = (r_state == S_LOAD);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    pap_ram #(
        .WIDTH (PT_BITS),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pap_angle u_angle (
        .i_clk  (i_clk),
        .i_en   (r_state == S_MUL),
        .i_kdx  (r_kdx),
        .i_kdy  (r_kdy),
        .i_edx  (r_edx),
        .i_edy  (r_edy),
        .o_less (w_less)
    );

    // RAM port steering: load writes at the fill count, the sort shifts
    // elements up one slot and drops the key into the hole.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_j[ADDR_BITS-1:0];
        w_wdata = r_key;
        w_raddr = r_i[ADDR_BITS-1:0];
        unique case (r_state)
            S_LOAD: begin
                w_we    = w_accept && w_room;
                w_waddr = r_count[ADDR_BITS-1:0];
                w_wdata = '{x_coord: i_vtx.data.x_coord, y_coord: i_vtx.data.y_coord};
            end
            S_E_RD: begin
                w_raddr = ADDR_BITS'(r_j - 1'b1);
            end
            S_CMP: begin
                w_we    = 1'b1;
                w_wdata = w_less ? r_e : r_key;
            end
            S_PUT: begin
                w_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (w_accept && i_vtx.data.last_vertex) begin
                    n_state = (w_cnt_next > CNT_BITS'(1)) ? S_KEY_RD : S_A_RD;
                end
            end
            S_KEY_RD:   n_state = S_KEY_WAIT;
            S_KEY_WAIT: n_state = S_E_RD;
            S_E_RD:     n_state = S_E_WAIT;
            S_E_WAIT:   n_state = S_MUL;
            S_MUL:      n_state = S_CMP;
            S_CMP: begin
                if (w_less) begin
                    n_state = (r_j == CNT_BITS'(1)) ? S_PUT : S_E_RD;
                end else begin
                    n_state = w_i_last ? S_A_RD : S_KEY_RD;
                end
            end
            S_PUT:    n_state = w_i_last ? S_A_RD : S_KEY_RD;
            S_A_RD:   n_state = S_A_WAIT;
            S_A_WAIT: begin
                if (r_i == '0) begin
                    n_state = (r_count == CNT_BITS'(1)) ? S_A_WRAP : S_A_RD;
                end else begin
                    n_state = S_A_MUL;
                end
            end
            S_A_WRAP: n_state = S_A_MUL;
            S_A_MUL:  n_state = S_A_ACC;
            S_A_ACC: begin
                if (r_wrap) begin
                    n_state = S_DONE;
                end else begin
                    n_state = w_i_last ? S_A_WRAP : S_A_RD;
                end
            end
            S_DONE: begin
                if (!r_out_valid) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // Polygon bookkeeping and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_LOAD && w_accept) begin
                if (w_room) begin
                    r_count <= r_count + 1'b1;
                    r_sum_x <= r_sum_x + SUM_BITS'(i_vtx.data.x_coord);
                    r_sum_y <= r_sum_y + SUM_BITS'(i_vtx.data.y_coord);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (r_state == S_DONE && !r_out_valid) begin
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_sum_x     <= '0;
                r_sum_y     <= '0;
                r_ovf       <= 1'b0;
            end
        end
    end

    // Sort and area datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_LOAD: begin
                r_i    <= (w_cnt_next > CNT_BITS'(1)) ? CNT_BITS'(1) : '0;
                r_acc  <= '0;
                r_wrap <= 1'b0;
            end
            S_KEY_WAIT: begin
                r_key <= w_rpt;
                r_kdx <= centered(w_rpt.x_coord, r_count, r_sum_x);
                r_kdy <= centered(w_rpt.y_coord, r_count, r_sum_y);
                r_j   <= r_i;
            end
            S_E_WAIT: begin
                r_e   <= w_rpt;
                r_edx <= centered(w_rpt.x_coord, r_count, r_sum_x);
                r_edy <= centered(w_rpt.y_coord, r_count, r_sum_y);
            end
            S_CMP: begin
                if (w_less) begin
                    r_j <= r_j - 1'b1;
                end else if (w_i_last) begin
                    r_i <= '0;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            S_PUT: begin
                r_i <= w_i_last ? '0 : r_i + 1'b1;
            end
            S_A_WAIT: begin
                r_cur <= w_rpt;
                if (r_i == '0) begin
                    r_first <= w_rpt;
                    r_prev  <= w_rpt;
                    r_i     <= CNT_BITS'(1);
                end
            end
            S_A_WRAP: begin
                r_cur  <= r_first;
                r_wrap <= 1'b1;
            end
            S_A_MUL: begin
                r_t1 <= r_prev.x_coord * r_cur.y_coord;
                r_t2 <= r_cur.x_coord * r_prev.y_coord;
            end
            S_A_ACC: begin
                r_acc  <= r_acc + ACC_BITS'(r_t1) - ACC_BITS'(r_t2);
                r_prev <= r_cur;
                if (!r_wrap) begin
                    r_i <= r_i + 1'b1;
                end
            end
            S_DONE: begin
                // hold the previous word while it still waits for the receiver
                if (!r_out_valid) begin
                    r_out.double_area     <= w_abs[AREA_BITS-1:0];
                    r_out.too_many_points <= r_ovf;
                end
            end
            default: begin
            end
        endcase
    end

    // Fill count never passes the RAM depth
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(MAX_POINTS))
        else $error("point count beyond capacity");

    // Issuing a result clears the polygon bookkeeping in the same edge
    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_count == '0 && !r_ovf && r_sum_x == '0))
        else $error("polygon state not cleared at close");

    // Inner sort index stays inside the sorted prefix
    a_sort_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_j != '0 && r_j <= r_i && r_i < r_count))
        else $error("sort index out of range");

    // The area pass never writes the point RAM
    a_area_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_LOAD || r_state == S_CMP || r_state == S_PUT))
        else $error("point RAM written outside load or sort");

    // A held result is never overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> r_out_valid && $stable(r_out))
        else $error("result overwritten while stalled");
endmodule
